>>> rtl/core/nsa_pkg.sv
// ----------------------------------------------------------------------------
// nsa_pkg: shared types and codes of the NFA string acceptor
// Request codes, configuration register indexes, the command word that
// travels from the front to the back, and the back's status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package nsa_pkg;

	// Fixed field widths of the item and configuration ports
	localparam int REQ_W  = 2;
	localparam int SRC_W  = 4;
	localparam int SYM_W  = 8;
	localparam int MASK_W = 16;
	localparam int CIDX_W = 1;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SYM   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_EMPTY = 2'd2;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_START = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_FINAL = 1'b1;

	// Classified command held in the front queue
	typedef struct packed {
		logic [REQ_W-1:0]  op;
		logic [SRC_W-1:0]  src;
		logic [SYM_W-1:0]  sym;
		logic [MASK_W-1:0] nxt;
		logic              last;
	} cmd_t;

	// Back-end status seen by the front
	typedef struct packed {
		logic clearing;
		logic take;
	} bk_status_t;

endpackage

`default_nettype wire

>>> rtl/core/nfa_string_acceptor.sv
// ----------------------------------------------------------------------------
// nfa_string_acceptor: bit-parallel NFA simulation over byte symbols
// A front end classifies incoming items into a short queue; a back end
// keeps the transition table in RAM and advances the active-state set.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------------
//  input     push / full          req_type, source_state, symbol,
//                                 next_states, is_last
//  result    empty / pop          accepted
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A symbol item is scanned through the single table read port, which
//  visits one state per cycle, then drained into the active set; a last
//  symbol also loads the result register. A table write reads the entry,
//  then writes back the OR. An empty-string query loads the result directly.
//  After reset the table is swept to zero, one entry per cycle, over
//  NUM_STATES rounded up to a power of two times 2**SYMBOL_BITS entries
//  (4096 at the defaults); full stays high meanwhile.
//  The input queue keeps taking items while a result waits to be popped.
//
`default_nettype none

module nfa_string_acceptor #(
	parameter int NUM_STATES  = 16,
	parameter int SYMBOL_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Input channel
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [nsa_pkg::REQ_W-1:0]  req_type,
	input  wire logic [nsa_pkg::SRC_W-1:0]  source_state,
	input  wire logic [nsa_pkg::SYM_W-1:0]  symbol,
	input  wire logic [nsa_pkg::MASK_W-1:0] next_states,
	input  wire logic                       is_last,
	// Result channel
	output logic                            empty,
	input  wire logic                       pop,
	output logic                            accepted,
	// Configuration channel
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [nsa_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [nsa_pkg::MASK_W-1:0] cfg_data
);

	import nsa_pkg::*;

	logic [SRC_W-1:0]  start_state_q;
	logic [MASK_W-1:0] final_mask_q;
	bk_status_t        bk;
	cmd_t              head;
	logic              avail;

	// Configuration is taken on any cycle; a transaction lands in its register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
			final_mask_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START: start_state_q <= cfg_data[SRC_W-1:0];
				CFG_FINAL: final_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: accept, drop no-op items, queue the rest
	nsa_front #(
		.NUM_STATES(NUM_STATES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.source_state(source_state),
		.symbol      (symbol),
		.next_states (next_states),
		.is_last     (is_last),
		.bk          (bk),
		.head        (head),
		.avail       (avail)
	);

	// Back: table sweep, updates, set stepping, result register
	nsa_back #(
		.NUM_STATES (NUM_STATES),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.avail      (avail),
		.bk         (bk),
		.start_state(start_state_q),
		.final_mask (final_mask_q),
		.empty      (empty),
		.pop        (pop),
		.accepted   (accepted)
	);

endmodule

`default_nettype wire

>>> rtl/core/nsa_ram.sv
// ----------------------------------------------------------------------------
// nsa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/nsa_front.sv
// ----------------------------------------------------------------------------
// nsa_front: input acceptance and classification
// Takes items from the push side, drops those with no effect, and holds
// the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nsa_front #(
	parameter int NUM_STATES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [nsa_pkg::REQ_W-1:0]  req_type,
	input  wire logic [nsa_pkg::SRC_W-1:0]  source_state,
	input  wire logic [nsa_pkg::SYM_W-1:0]  symbol,
	input  wire logic [nsa_pkg::MASK_W-1:0] next_states,
	input  wire logic                       is_last,
	input  wire nsa_pkg::bk_status_t        bk,
	output nsa_pkg::cmd_t                   head,
	output logic                            avail
);

	import nsa_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       keep;
	logic       deq;
	cmd_t       cmd;

	assign full   = (cnt_q == 2'd2) || bk.clearing;
	assign accept = push && !full;
	assign avail  = (cnt_q != 2'd0);
	assign head   = slot_q[rd_ptr_q];
	assign deq    = bk.take && avail;

	// Drop the unused request code and table writes to states that do not exist
	always_comb begin
		unique case (req_type) inside
			REQ_SYM, REQ_EMPTY: keep = 1'b1;
			REQ_ADD:            keep = (32'(source_state) < 32'(NUM_STATES));
			default:            keep = 1'b0;
		endcase
	end

	always_comb begin
		cmd.op   = req_type;
		cmd.src  = source_state;
		cmd.sym  = symbol;
		cmd.nxt  = next_states;
		cmd.last = is_last;
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			slot_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'((accept && keep) ? 1 : 0) - 2'(deq ? 1 : 0);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nsa_back.sv
// ----------------------------------------------------------------------------
// nsa_back: command execution
// Clears the transition table after reset, performs table updates, steps
// the active-state set one state per cycle, and holds one result.
// ----------------------------------------------------------------------------
`default_nettype none

module nsa_back #(
	parameter int NUM_STATES  = 16,
	parameter int SYMBOL_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire nsa_pkg::cmd_t              head,
	input  wire logic                       avail,
	output nsa_pkg::bk_status_t             bk,
	input  wire logic [nsa_pkg::SRC_W-1:0]  start_state,
	input  wire logic [nsa_pkg::MASK_W-1:0] final_mask,
	output logic                            empty,
	input  wire logic                       pop,
	output logic                            accepted
);

	import nsa_pkg::*;

	localparam int SIDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int ADDR_W = SIDX_W + SYMBOL_BITS;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam logic [SIDX_W-1:0] IDX_LAST = SIDX_W'(NUM_STATES - 1);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_ADD_WR = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0]            state_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [NUM_STATES-1:0] nxt_q;
	logic [NUM_STATES-1:0] active_q;
	logic [NUM_STATES-1:0] cur_q;
	logic [NUM_STATES-1:0] acc_q;
	logic [SIDX_W-1:0]     idx_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic                  last_q;
	logic                  rbit_q;
	logic                  in_string_q;
	logic                  res_q;
	logic                  out_valid_q;
	logic                  out_acc_q;

	logic [NUM_STATES-1:0] start_set;
	logic [NUM_STATES-1:0] fm_ext;
	logic [NUM_STATES-1:0] head_nxt;
	logic [NUM_STATES-1:0] rdata;
	logic [NUM_STATES-1:0] nset;
	logic [NUM_STATES-1:0] wdata;
	logic [ADDR_W-1:0]     raddr;
	logic [ADDR_W-1:0]     waddr;
	logic [ADDR_W-1:0]     head_addr;
	logic                  we;
	logic                  out_free;

	// Map the fixed-width masks onto the state vector
	for (genvar i = 0; i < NUM_STATES; i++) begin : g_map
		if (i < MASK_W) begin : g_in
			assign fm_ext[i]   = final_mask[i];
			assign head_nxt[i] = head.nxt[i];
		end else begin : g_out
			assign fm_ext[i]   = 1'b0;
			assign head_nxt[i] = 1'b0;
		end
		assign start_set[i] = (32'(start_state) == i);
	end

	assign head_addr = {SIDX_W'(head.src), head.sym[SYMBOL_BITS-1:0]};
	assign nset      = acc_q | (rbit_q ? rdata : '0);
	assign out_free  = !out_valid_q || pop;

	assign bk.clearing = (state_q == ST_CLEAR);
	assign bk.take     = (state_q == ST_IDLE) && avail;

	assign empty    = !out_valid_q;
	assign accepted = out_acc_q;

	always_comb begin
		raddr = head_addr;
		waddr = addr_q;
		wdata = rdata | nxt_q;
		we    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				waddr = clr_q;
				wdata = '0;
				we    = 1'b1;
			end
			ST_ADD_WR: we = 1'b1;
			ST_SCAN:   raddr = {idx_q, sym_q};
			default: ;
		endcase
	end

	nsa_ram #(
		.WIDTH(NUM_STATES),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				addr_q <= head_addr;
				nxt_q  <= head_nxt;
				sym_q  <= head.sym[SYMBOL_BITS-1:0];
				last_q <= head.last;
				cur_q  <= in_string_q ? active_q : start_set;
				acc_q  <= '0;
				rbit_q <= 1'b0;
			end
			ST_SCAN: begin
				acc_q  <= nset;
				rbit_q <= cur_q[idx_q];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			active_q    <= '0;
			in_string_q <= 1'b0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_acc_q   <= 1'b0;
		end else begin
			// a result loading in the same cycle keeps the register full
			if (pop && out_valid_q && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q <= '0;
					if (avail) begin
						case (head.op)
							REQ_ADD: state_q <= ST_ADD_WR;
							REQ_SYM: state_q <= ST_SCAN;
							default: begin
								in_string_q <= 1'b0;
								res_q       <= |(start_set & fm_ext);
								state_q     <= ST_RESULT;
							end
						endcase
					end
				end
				ST_ADD_WR: state_q <= ST_IDLE;
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					active_q <= nset;
					if (last_q) begin
						in_string_q <= 1'b0;
						res_q       <= |(nset & fm_ext);
						state_q     <= ST_RESULT;
					end else begin
						in_string_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_acc_q   <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nsa_checker.sv
// ----------------------------------------------------------------------------
// nsa_props: port-level checks of the NFA string acceptor
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module nsa_props (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       push,
	input wire logic                       full,
	input wire logic [nsa_pkg::REQ_W-1:0]  req_type,
	input wire logic                       is_last,
	input wire logic                       empty,
	input wire logic                       pop,
	input wire logic                       accepted,
	input wire logic                       cfg_ready
);

	import nsa_pkg::*;

	logic [3:0] pend_q;
	logic       gives;
	logic       took;

	// Count accepted transactions that owe a result, less results popped
	assign gives = push && !full &&
		((req_type == REQ_SYM && is_last) || req_type == REQ_EMPTY);
	assign took  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 4'(gives ? 1 : 0) - 4'(took ? 1 : 0);
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before pop");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(accepted))
		else $error("result changed before pop");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pend_q != 4'd0))
		else $error("result shown with no owing transaction");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

endmodule

bind nfa_string_acceptor nsa_props u_nsa_props (.*);

`default_nettype wire
